// ----- hw/rtl/acas_pkg.sv -----
// ----------------------------------------------------------------------------
// acas_pkg
// Shared sizes, action codes and the per-channel record of the ADC channel
// average scaler.
// ----------------------------------------------------------------------------
package acas_pkg;

  localparam int CHANNEL_COUNT = 10;
  localparam int AVERAGE_LOG2  = 3;
  localparam int RING_LEN      = 1 << AVERAGE_LOG2;

  localparam int CH_W       = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int HIST_DEPTH = CHANNEL_COUNT * RING_LEN;
  localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int TOTAL_W    = 16 + AVERAGE_LOG2;

  localparam logic [1:0] ACT_SAMPLE    = 2'd0;
  localparam logic [1:0] ACT_LOAD      = 2'd1;
  localparam logic [1:0] ACT_CALIBRATE = 2'd2;
  localparam logic [1:0] ACT_READ      = 2'd3;

  typedef logic [CH_W-1:0]         ch_idx_t;
  typedef logic [AVERAGE_LOG2-1:0] ring_ptr_t;
  typedef logic [HIST_AW-1:0]      hist_addr_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total;
    logic signed [15:0]        offset;
    logic signed [15:0]        gain;
    logic [3:0]                shift;
  } chan_rec_t;

  localparam int REC_W = $bits(chan_rec_t);

endpackage

// ----- hw/rtl/acas_ifs.sv -----
// ----------------------------------------------------------------------------
// acas stream interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface acas_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [3:0]         channel;
  logic signed [15:0] sample;
  logic signed [15:0] gain;
  logic [3:0]         gain_shift;
  logic signed [15:0] zero_offset;

  modport source (
    output valid, action, channel, sample, gain, gain_shift, zero_offset,
    input  ready
  );
  modport sink (
    input  valid, action, channel, sample, gain, gain_shift, zero_offset,
    output ready
  );
endinterface

interface acas_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] instant_value;
  logic signed [15:0] average_value;
  logic               channel_valid;

  modport source (
    output valid, instant_value, average_value, channel_valid,
    input  ready
  );
  modport sink (
    input  valid, instant_value, average_value, channel_valid,
    output ready
  );
endinterface

// ----- hw/rtl/adc_channel_average_scaler_top.sv -----
// ----------------------------------------------------------------------------
// adc_channel_average_scaler_top
// Per-channel moving average with offset and gain correction.
//
// The req channel carries one action per item: sample, load coefficients,
// calibrate offset from the current average, or read. Every item yields
// exactly one rsp item with the channel's instant and average values: new
// scaled ones for a sample, the last sample's for other actions, and zeros
// for a channel number at or above the channel count. Results pass the s1,
// s2, s3 and rsp registers. One item is accepted every cycle unless rsp
// stalls; the per-channel record memory is read at acceptance, updated and
// written back in s1, and a bypass register covers back-to-back items on
// the same channel. Reset clears the ring pointers and the valid bits of the
// history and record memories, so all channel state reads as zero at once;
// there is no clearing pass. When rsp is stalled the whole pipeline holds
// and req.ready drops until the held result is taken.
// ----------------------------------------------------------------------------
module adc_channel_average_scaler_top (
  input logic        clk,
  input logic        rst,
  acas_in_if.sink    req,
  acas_out_if.source rsp
);
  import acas_pkg::*;

  logic advance;
  logic accept;
  logic in_range0;
  ch_idx_t    ch0;
  ring_ptr_t  ptr_cur;
  hist_addr_t haddr0;

  ring_ptr_t ptr_mem [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] cvalid;
  logic [HIST_DEPTH-1:0]    hvalid;

  // Stage 1
  logic               s1_valid;
  logic [1:0]         s1_action;
  ch_idx_t            s1_ch;
  logic               s1_in_range;
  logic signed [15:0] s1_sample;
  logic signed [15:0] s1_gain;
  logic [3:0]         s1_shift;
  logic signed [15:0] s1_offset;
  hist_addr_t         s1_haddr;

  logic [REC_W-1:0]   chan_rdata;
  logic [15:0]        hist_rdata;
  logic               wb_valid;
  ch_idx_t            wb_ch;
  chan_rec_t          wb_rec;
  chan_rec_t          rec_cur;
  chan_rec_t          rec_new;
  logic               rec_we;
  logic               hist_we;
  logic signed [15:0] hist_old;
  logic signed [TOTAL_W-1:0] total_new;
  logic signed [15:0] mean_new;
  logic signed [15:0] mean_cur;
  logic signed [15:0] d_inst;
  logic signed [15:0] d_avg;

  // Stage 2
  logic               s2_valid;
  logic [1:0]         s2_action;
  ch_idx_t            s2_ch;
  logic               s2_in_range;
  logic signed [15:0] s2_d_inst;
  logic signed [15:0] s2_d_avg;
  logic signed [15:0] s2_gain;
  logic [3:0]         s2_shift;

  // Stage 3
  logic               s3_valid;
  logic [1:0]         s3_action;
  ch_idx_t            s3_ch;
  logic               s3_in_range;
  logic signed [15:0] inst_calc;
  logic signed [15:0] avg_calc;
  logic signed [15:0] inst_sel;
  logic signed [15:0] avg_sel;
  logic               last_we;

  logic signed [15:0] last_inst [CHANNEL_COUNT];
  logic signed [15:0] last_avg  [CHANNEL_COUNT];

  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = advance;
  assign accept    = req.valid && advance;

  assign in_range0 = int'(req.channel) < CHANNEL_COUNT;
  assign ch0       = in_range0 ? req.channel[CH_W-1:0] : '0;
  assign ptr_cur   = ptr_mem[ch0];
  assign haddr0    = HIST_AW'({ch0, ptr_cur});

  // The ring pointer moves at acceptance, so the next item already sees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        ptr_mem[i] <= '0;
      end
    end else if (accept && in_range0 && req.action == ACT_SAMPLE) begin
      ptr_mem[ch0] <= ptr_cur + 1'b1;
    end
  end

  acas_ram #(.WIDTH(16), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (s1_haddr),
    .wdata (s1_sample),
    .re    (advance),
    .raddr (haddr0),
    .rdata (hist_rdata)
  );

  acas_ram #(.WIDTH(REC_W), .DEPTH(CHANNEL_COUNT)) u_chan_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (s1_ch),
    .wdata (rec_new),
    .re    (advance),
    .raddr (ch0),
    .rdata (chan_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_action   <= req.action;
      s1_ch       <= ch0;
      s1_in_range <= in_range0;
      s1_sample   <= req.sample;
      s1_gain     <= req.gain;
      s1_shift    <= req.gain_shift;
      s1_offset   <= req.zero_offset;
      s1_haddr    <= haddr0;
    end
  end

  // The record written in the previous step is not yet visible in the read
  // data, so it is taken from the bypass register instead.
  always_comb begin
    if (wb_valid && wb_ch == s1_ch) begin
      rec_cur = wb_rec;
    end else if (cvalid[s1_ch]) begin
      rec_cur = chan_rdata;
    end else begin
      rec_cur = '0;
    end
  end

  assign hist_old  = hvalid[s1_haddr] ? hist_rdata : 16'sd0;
  assign total_new = rec_cur.total - TOTAL_W'(hist_old) + TOTAL_W'(s1_sample);
  assign mean_new  = total_new[TOTAL_W-1:AVERAGE_LOG2];
  assign mean_cur  = rec_cur.total[TOTAL_W-1:AVERAGE_LOG2];
  assign d_inst    = s1_sample - rec_cur.offset;
  assign d_avg     = mean_new - rec_cur.offset;

  always_comb begin
    rec_new = rec_cur;
    unique case (s1_action)
      ACT_SAMPLE: begin
        rec_new.total = total_new;
      end
      ACT_LOAD: begin
        rec_new.gain   = s1_gain;
        rec_new.shift  = s1_shift;
        rec_new.offset = s1_offset;
      end
      ACT_CALIBRATE: begin
        rec_new.offset = mean_cur;
      end
      ACT_READ: begin
      end
      default: begin
      end
    endcase
  end

  assign rec_we  = advance && s1_valid && s1_in_range && s1_action != ACT_READ;
  assign hist_we = advance && s1_valid && s1_in_range && s1_action == ACT_SAMPLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
      cvalid   <= '0;
      hvalid   <= '0;
    end else begin
      if (advance) begin
        wb_valid <= rec_we;
      end
      if (rec_we) begin
        cvalid[s1_ch] <= 1'b1;
      end
      if (hist_we) begin
        hvalid[s1_haddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wb_ch  <= s1_ch;
      wb_rec <= rec_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_action   <= s1_action;
      s2_ch       <= s1_ch;
      s2_in_range <= s1_in_range;
      s2_d_inst   <= d_inst;
      s2_d_avg    <= d_avg;
      s2_gain     <= rec_cur.gain;
      s2_shift    <= rec_cur.shift;
      s3_action   <= s2_action;
      s3_ch       <= s2_ch;
      s3_in_range <= s2_in_range;
    end
  end

  acas_scale u_scale_inst (
    .clk    (clk),
    .en     (advance),
    .diff   (s2_d_inst),
    .gain   (s2_gain),
    .shift  (s2_shift),
    .result (inst_calc)
  );

  acas_scale u_scale_avg (
    .clk    (clk),
    .en     (advance),
    .diff   (s2_d_avg),
    .gain   (s2_gain),
    .shift  (s2_shift),
    .result (avg_calc)
  );

  always_comb begin
    if (!s3_in_range) begin
      inst_sel = 16'sd0;
      avg_sel  = 16'sd0;
    end else if (s3_action == ACT_SAMPLE) begin
      inst_sel = inst_calc;
      avg_sel  = avg_calc;
    end else begin
      inst_sel = last_inst[s3_ch];
      avg_sel  = last_avg[s3_ch];
    end
  end

  assign last_we = advance && s3_valid && s3_in_range && s3_action == ACT_SAMPLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        last_inst[i] <= '0;
        last_avg[i]  <= '0;
      end
    end else if (last_we) begin
      last_inst[s3_ch] <= inst_calc;
      last_avg[s3_ch]  <= avg_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.instant_value <= inst_sel;
      rsp.average_value <= avg_sel;
      rsp.channel_valid <= s3_in_range;
    end
  end

endmodule

// ----- hw/rtl/acas_ram.sv -----
// ----------------------------------------------------------------------------
// acas_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module acas_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address written in the same cycle returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/acas_scale.sv -----
// ----------------------------------------------------------------------------
// acas_scale
// Gain stage: registered signed 16x16 product, then arithmetic right shift
// and wrap to 16 bits.
// ----------------------------------------------------------------------------
module acas_scale (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] diff,
  input  logic signed [15:0] gain,
  input  logic [3:0]         shift,
  output logic signed [15:0] result
);

  logic signed [31:0] product;
  logic [3:0]         shift_q;
  logic signed [31:0] shifted;

  always_ff @(posedge clk) begin
    if (en) begin
      product <= 32'(diff) * 32'(gain);
      shift_q <= shift;
    end
  end

  assign shifted = product >>> shift_q;
  assign result  = shifted[15:0];

endmodule
